// File: sv/assert_macros.svh
// assertion helpers, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent check on the rising edge of clk
`define CHECK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication whose consequent is checked in the next cycle
`define CHECK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/jlvd_pkg.sv
package jlvd_pkg;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // joint index codes carried by the input field
  localparam int JOINT_CODES = 64;

  localparam logic [1:0] ZONE_FREE = 2'd0;
  localparam logic [1:0] ZONE_LOW  = 2'd1;
  localparam logic [1:0] ZONE_UPP  = 2'd2;

  localparam logic [1:0] CFG_TIME_STEP     = 2'd0;
  localparam logic [1:0] CFG_DAMPER_OFFSET = 2'd1;
  localparam logic [1:0] CFG_INFLUENCE     = 2'd2;
  localparam logic [1:0] CFG_SECURITY      = 2'd3;

  typedef enum logic [2:0] {
    DIV_LO = 3'd0,
    DIV_UP = 3'd1,
    DIV_G  = 3'd2,
    DIV_M  = 3'd3,
    DIV_C  = 3'd4
  } div_sel_t;

  typedef struct packed {
    logic     clear;
    logic     load_in;
    logic     calc_range;
    logic     calc_dist;
    logic     div_start;
    div_sel_t div_sel;
    logic     decide;
    logic     mul_g;
    logic     gain_upd;
    logic     mul_m;
    logic     cand_num;
    logic     finish;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic active;
    logic div_done;
    logic target_free;
    logic need_latch;
    logic out_free;
  } sts_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    if (x[32] != x[31]) begin
      return x[32] ? S32_MIN : S32_MAX;
    end
    return x[31:0];
  endfunction

endpackage

// File: sv/jlvd_div.sv
module jlvd_div
  import jlvd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [32:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] quo;
  logic [33:0] rem;
  logic [32:0] dmag;
  logic        neg;
  logic        dzero;
  logic        npos;
  logic        nneg;

  logic [33:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem[32:0], quo[63]};
  assign ge     = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num[63] ? 64'(-num) : 64'(num);
      dmag  <= den[32] ? 33'(-den) : 33'(den);
      rem   <= '0;
      neg   <= num[63] ^ den[32];
      dzero <= (den == '0);
      npos  <= !num[63] && (num != '0);
      nneg  <= num[63];
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, dmag}) : rem_sh;
      quo <= {quo[62:0], ge};
    end
  end

  always_comb begin
    if (dzero) begin
      quot = npos ? S32_MAX : (nneg ? S32_MIN : '0);
    end else if (!neg) begin
      quot = (|quo[63:31]) ? S32_MAX : {1'b0, quo[30:0]};
    end else begin
      quot = (quo > 64'h0000_0000_8000_0000) ? S32_MIN : -(quo[31:0]);
    end
  end

endmodule

// File: sv/jlvd_dp.sv
module jlvd_dp
  import jlvd_pkg::*;
#(
  parameter int JOINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic [5:0]         joint,
  input  logic               active,
  input  logic signed [31:0] position,
  input  logic signed [31:0] velocity,
  input  logic signed [31:0] pos_min,
  input  logic signed [31:0] pos_max,
  input  logic signed [31:0] vel_min,
  input  logic signed [31:0] vel_max,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [5:0]         joint_out,
  output logic               bounded,
  output logic signed [31:0] accel_lower,
  output logic signed [31:0] accel_upper,
  output logic [1:0]         zone
);

  localparam int SLOT_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  logic [30:0] time_step;
  logic [30:0] damper_offset;
  logic [15:0] influence_fraction;
  logic [15:0] security_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step          <= 31'd655;
      damper_offset      <= '0;
      influence_fraction <= 16'd6554;
      security_fraction  <= 16'd655;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_STEP:     time_step          <= cfg_data;
        CFG_DAMPER_OFFSET: damper_offset      <= cfg_data;
        CFG_INFLUENCE:     influence_fraction <= cfg_data[15:0];
        CFG_SECURITY:      security_fraction  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // joint code to state slot, folded at elaboration
  logic [SLOT_W-1:0] slot_tab [JOINT_CODES];
  for (genvar g = 0; g < JOINT_CODES; g++) begin : g_slot
    assign slot_tab[g] = SLOT_W'(g % JOINTS);
  end

  logic [5:0]         joint_r;
  logic               act_r;
  logic [SLOT_W-1:0]  slot_r;
  logic signed [31:0] pos_r, vel_r, pmin_r, pmax_r, vmin_r, vmax_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      joint_r <= joint;
      act_r   <= active;
      slot_r  <= slot_tab[joint];
      pos_r   <= position;
      vel_r   <= velocity;
      pmin_r  <= pos_min;
      pmax_r  <= pos_max;
      vmin_r  <= vel_min;
      vmax_r  <= vel_max;
    end
  end

  // per-joint state: zone in the top two bits, gain below
  logic [33:0]       mem [JOINTS];
  logic [33:0]       rd_q;
  logic [SLOT_W-1:0] clr_cnt;
  logic [1:0]        zone_r;
  logic signed [31:0] gain_r;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_cnt] <= '0;
    end else if (cmd.finish) begin
      mem[slot_r] <= {zone_r, gain_r};
    end
    if (cmd.load_in) begin
      rd_q <= mem[slot_tab[joint]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  logic signed [31:0] range_r, ld_r, ud_r, idist_r, sdist_r;
  logic signed [48:0] prod_i, prod_s;

  assign prod_i = range_r * $signed({1'b0, influence_fraction});
  assign prod_s = range_r * $signed({1'b0, security_fraction});

  always_ff @(posedge clk) begin
    if (cmd.calc_range) begin
      range_r <= sat33(33'(pmax_r) - 33'(pmin_r));
      ld_r    <= sat33(33'(pos_r) - 33'(pmin_r));
      ud_r    <= sat33(33'(pmax_r) - 33'(pos_r));
    end
    if (cmd.calc_dist) begin
      // arithmetic shift gives the floor
      idist_r <= prod_i[47:16];
      sdist_r <= prod_s[47:16];
    end
  end

  logic [1:0]         target_r;
  logic signed [32:0] dms_r, ims_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] cnum_r;
  logic signed [31:0] lower_r, upper_r, gq_r, mq_r, cq_r;
  logic signed [64:0] pg, pm;
  logic signed [32:0] lo_diff, up_diff, absg, cand_x;
  logic signed [31:0] negm;
  logic [33:0]        gsum;

  assign pg      = ims_r * vel_r;
  assign pm      = gain_r * dms_r;
  assign lo_diff = 33'(vmin_r) - 33'(vel_r);
  assign up_diff = 33'(vmax_r) - 33'(vel_r);
  assign absg    = gq_r[31] ? -33'(gq_r) : 33'(gq_r);
  assign gsum    = {1'b0, absg} + {3'b0, damper_offset};
  assign negm    = (mq_r == S32_MIN) ? S32_MAX : -mq_r;
  assign cand_x  = ((target_r == ZONE_LOW) ? 33'(negm) : 33'(mq_r)) - 33'(vel_r);

  logic signed [63:0] div_num;
  logic signed [32:0] div_den;
  logic               div_done;
  logic signed [31:0] div_q;
  div_sel_t           dsel_r;

  always_comb begin
    case (cmd.div_sel)
      DIV_LO: begin
        div_num = {{15{lo_diff[32]}}, lo_diff, 16'b0};
        div_den = {2'b0, time_step};
      end
      DIV_UP: begin
        div_num = {{15{up_diff[32]}}, up_diff, 16'b0};
        div_den = {2'b0, time_step};
      end
      DIV_G: begin
        div_num = prod_r;
        div_den = dms_r;
      end
      DIV_M: begin
        div_num = prod_r;
        div_den = ims_r;
      end
      default: begin
        div_num = cnum_r;
        div_den = {2'b0, time_step};
      end
    endcase
  end

  jlvd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dsel_r <= cmd.div_sel;
    end
    if (cmd.load_in) begin
      lower_r <= S32_MIN;
      upper_r <= S32_MAX;
    end else if (div_done) begin
      case (dsel_r)
        DIV_LO:  lower_r <= div_q;
        DIV_UP:  upper_r <= div_q;
        DIV_G:   gq_r    <= div_q;
        DIV_M:   mq_r    <= div_q;
        default: cq_r    <= div_q;
      endcase
    end else if (cmd.finish) begin
      if (target_r == ZONE_LOW && cq_r > lower_r) begin
        lower_r <= cq_r;
      end
      if (target_r == ZONE_UPP && cq_r < upper_r) begin
        upper_r <= cq_r;
      end
    end

    if (cmd.calc_range) begin
      zone_r <= rd_q[33:32];
      gain_r <= rd_q[31:0];
    end else if (cmd.decide) begin
      if (!(ld_r < idist_r) && !(ud_r < idist_r)) begin
        zone_r <= ZONE_FREE;
      end
    end else if (cmd.gain_upd) begin
      zone_r <= target_r;
      gain_r <= (|gsum[33:31]) ? S32_MAX : $signed(gsum[31:0]);
    end

    if (cmd.decide) begin
      ims_r <= 33'(idist_r) - 33'(sdist_r);
      if (ld_r < idist_r) begin
        target_r <= ZONE_LOW;
        dms_r    <= 33'(ld_r) - 33'(sdist_r);
      end else if (ud_r < idist_r) begin
        target_r <= ZONE_UPP;
        dms_r    <= 33'(ud_r) - 33'(sdist_r);
      end else begin
        target_r <= ZONE_FREE;
        dms_r    <= '0;
      end
    end
    if (cmd.mul_g) begin
      prod_r <= pg[63:0];
    end else if (cmd.mul_m) begin
      prod_r <= pm[63:0];
    end
    if (cmd.cand_num) begin
      cnum_r <= {{15{cand_x[32]}}, cand_x, 16'b0};
    end
  end

  // output register, frees the core while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      joint_out   <= joint_r;
      bounded     <= act_r;
      accel_lower <= lower_r;
      accel_upper <= upper_r;
      zone        <= zone_r;
    end
  end

  assign sts.clear_last  = (clr_cnt == SLOT_W'(JOINTS - 1));
  assign sts.active      = act_r;
  assign sts.div_done    = div_done;
  assign sts.target_free = (target_r == ZONE_FREE);
  assign sts.need_latch  = (zone_r != target_r);
  assign sts.out_free    = !out_valid || !out_stall;

endmodule

// File: sv/jlvd_ctrl.sv
module jlvd_ctrl
  import jlvd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [21:0] {
    ST_CLEAR  = 22'h000001,
    ST_IDLE   = 22'h000002,
    ST_RANGE  = 22'h000004,
    ST_DIST   = 22'h000008,
    ST_LO     = 22'h000010,
    ST_LO_W   = 22'h000020,
    ST_UP     = 22'h000040,
    ST_UP_W   = 22'h000080,
    ST_DECIDE = 22'h000100,
    ST_BRANCH = 22'h000200,
    ST_MULG   = 22'h000400,
    ST_DIVG   = 22'h000800,
    ST_DIVG_W = 22'h001000,
    ST_GAIN   = 22'h002000,
    ST_MULM   = 22'h004000,
    ST_DIVM   = 22'h008000,
    ST_DIVM_W = 22'h010000,
    ST_CNUM   = 22'h020000,
    ST_DIVC   = 22'h040000,
    ST_DIVC_W = 22'h080000,
    ST_FINISH = 22'h100000,
    ST_DONE   = 22'h200000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_LO;
    in_stall    = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_RANGE;
        end
      end
      ST_RANGE: begin
        cmd.calc_range = 1'b1;
        state_next = sts.active ? ST_DIST : ST_DONE;
      end
      ST_DIST: begin
        cmd.calc_dist = 1'b1;
        state_next    = ST_LO;
      end
      ST_LO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_LO;
        state_next    = ST_LO_W;
      end
      ST_LO_W: begin
        if (sts.div_done) state_next = ST_UP;
      end
      ST_UP: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_UP;
        state_next    = ST_UP_W;
      end
      ST_UP_W: begin
        if (sts.div_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_BRANCH;
      end
      ST_BRANCH: begin
        if (sts.target_free) begin
          state_next = ST_FINISH;
        end else if (sts.need_latch) begin
          state_next = ST_MULG;
        end else begin
          state_next = ST_MULM;
        end
      end
      ST_MULG: begin
        cmd.mul_g  = 1'b1;
        state_next = ST_DIVG;
      end
      ST_DIVG: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_G;
        state_next    = ST_DIVG_W;
      end
      ST_DIVG_W: begin
        if (sts.div_done) state_next = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain_upd = 1'b1;
        state_next   = ST_MULM;
      end
      ST_MULM: begin
        cmd.mul_m  = 1'b1;
        state_next = ST_DIVM;
      end
      ST_DIVM: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_M;
        state_next    = ST_DIVM_W;
      end
      ST_DIVM_W: begin
        if (sts.div_done) state_next = ST_CNUM;
      end
      ST_CNUM: begin
        cmd.cand_num = 1'b1;
        state_next   = ST_DIVC;
      end
      ST_DIVC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_C;
        state_next    = ST_DIVC_W;
      end
      ST_DIVC_W: begin
        if (sts.div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: sv/joint_limit_velocity_damper.sv
// channel   | handshake           | beat
// ----------+---------------------+--------------------------------------------
// input     | in_valid/in_stall   | joint, active, position, velocity, limits
// output    | out_valid/out_stall | joint_out, bounded, accel_lower/upper, zone
// config    | cfg_we              | cfg_index, cfg_data
//
// one item at a time through a shared 64-step serial divider
// accept to next accept grows from an inactive joint through a free joint and a joint
// staying in a zone to a joint entering a zone (five divides)
// after reset a clearing pass over all JOINTS slots zeroes the joint state, no input taken
// a result waiting under out_stall does not hold off the next input beat
`include "assert_macros.svh"

module joint_limit_velocity_damper
  import jlvd_pkg::*;
#(
  parameter int JOINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         joint,
  input  logic               active,
  input  logic signed [31:0] position,
  input  logic signed [31:0] velocity,
  input  logic signed [31:0] pos_min,
  input  logic signed [31:0] pos_max,
  input  logic signed [31:0] vel_min,
  input  logic signed [31:0] vel_max,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         joint_out,
  output logic               bounded,
  output logic signed [31:0] accel_lower,
  output logic signed [31:0] accel_upper,
  output logic [1:0]         zone
);

  cmd_t cmd;
  sts_t sts;

  jlvd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  jlvd_dp #(
    .JOINTS (JOINTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .joint       (joint),
    .active      (active),
    .position    (position),
    .velocity    (velocity),
    .pos_min     (pos_min),
    .pos_max     (pos_max),
    .vel_min     (vel_min),
    .vel_max     (vel_max),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .joint_out   (joint_out),
    .bounded     (bounded),
    .accel_lower (accel_lower),
    .accel_upper (accel_upper),
    .zone        (zone)
  );

  `CHECK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")
  `CHECK_CLK(a_unbounded_open, (out_valid && !bounded) |-> (accel_lower == S32_MIN && accel_upper == S32_MAX), "inactive joint got a bound")
  `CHECK_CLK(a_zone_code, out_valid |-> (zone == ZONE_FREE || zone == ZONE_LOW || zone == ZONE_UPP), "bad zone code")

endmodule

// File: tb/joint_limit_velocity_damper_checker.sv
`timescale 1ns / 100ps

module joint_limit_velocity_damper_checker
  import jlvd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [5:0]         joint,
  input  logic               active,
  input  logic signed [31:0] position,
  input  logic signed [31:0] velocity,
  input  logic signed [31:0] pos_min,
  input  logic signed [31:0] pos_max,
  input  logic signed [31:0] vel_min,
  input  logic signed [31:0] vel_max,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [5:0]         joint_out,
  input  logic               bounded,
  input  logic signed [31:0] accel_lower,
  input  logic signed [31:0] accel_upper,
  input  logic [1:0]         zone,
  output int                 errors,
  output int                 pending,
  output int                 results_seen
);

  typedef struct packed {
    logic [5:0]         joint_out;
    logic               bounded;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic [1:0]         zone;
  } bound_t;

  localparam longint LMAX = 64'sd2147483647;
  localparam longint LMIN = -64'sd2147483648;

  bound_t     bound_q[$];
  logic [30:0] step_r, offset_r;
  logic [15:0] infl_r, secu_r;
  logic [1:0]  zone_mem[64];
  logic signed [31:0] gain_mem[64];

  function automatic longint clip(longint x);
    if (x > LMAX) return LMAX;
    if (x < LMIN) return LMIN;
    return x;
  endfunction

  function automatic longint qdiv(longint n, longint d);
    if (d == 0) return (n > 0) ? LMAX : (n < 0) ? LMIN : 0;
    return clip(n / d);
  endfunction

  function automatic longint frac_floor(longint x);
    if (x >= 0) return x / 65536;
    return -((-x + 65535) / 65536);
  endfunction

  function automatic longint per_step(longint x);
    return qdiv(x * 65536, longint'(step_r));
  endfunction

  function automatic bound_t damp_joint();
    bound_t r;
    longint lo, hi, rng, idist, sdist, ld, ud, d, g, m, cand;
    logic [1:0] tgt, zn;
    int slot;
    slot = joint;
    zn = zone_mem[slot];
    lo = LMIN;
    hi = LMAX;
    if (active) begin
      rng = clip(longint'(pos_max) - pos_min);
      idist = frac_floor(rng * longint'(infl_r));
      sdist = frac_floor(rng * longint'(secu_r));
      ld = clip(longint'(position) - pos_min);
      ud = clip(longint'(pos_max) - position);
      lo = per_step(longint'(vel_min) - velocity);
      hi = per_step(longint'(vel_max) - velocity);
      tgt = ZONE_FREE;
      d = 0;
      if (ld < idist) begin
        tgt = ZONE_LOW;
        d = ld;
      end else if (ud < idist) begin
        tgt = ZONE_UPP;
        d = ud;
      end
      if (tgt == ZONE_FREE) begin
        zn = ZONE_FREE;
      end else begin
        if (zn != tgt) begin
          g = qdiv((idist - sdist) * velocity, d - sdist);
          if (g < 0) g = -g;
          gain_mem[slot] = 32'(clip(g + longint'(offset_r)));
          zn = tgt;
        end
        m = qdiv(longint'(gain_mem[slot]) * (d - sdist), idist - sdist);
        if (tgt == ZONE_LOW) begin
          cand = per_step(clip(-m) - velocity);
          if (cand > lo) lo = cand;
        end else begin
          cand = per_step(m - velocity);
          if (cand < hi) hi = cand;
        end
      end
      zone_mem[slot] = zn;
    end
    r.joint_out = joint;
    r.bounded = active;
    r.lower = lo[31:0];
    r.upper = hi[31:0];
    r.zone = zn;
    return r;
  endfunction

  assign pending = bound_q.size();

  always @(posedge clk) begin
    bound_t want;
    if (rst) begin
      step_r <= 31'd655;
      offset_r <= '0;
      infl_r <= 16'd6554;
      secu_r <= 16'd655;
      for (int i = 0; i < 64; i++) begin
        zone_mem[i] = ZONE_FREE;
        gain_mem[i] = '0;
      end
      bound_q.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIME_STEP:     step_r <= cfg_data;
          CFG_DAMPER_OFFSET: offset_r <= cfg_data;
          CFG_INFLUENCE:     infl_r <= cfg_data[15:0];
          CFG_SECURITY:      secu_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (bound_q.size() == 0) begin
          $display("%0t: unexpected result joint %0d", $time, joint_out);
          errors <= errors + 1;
        end else begin
          want = bound_q.pop_front();
          if (want != {joint_out, bounded, accel_lower, accel_upper, zone}) begin
            $display("%0t: mismatch expected j=%0d b=%0d lo=%0d up=%0d z=%0d",
                     $time, want.joint_out, want.bounded, want.lower, want.upper,
                     want.zone);
            $display("%0t:            actual j=%0d b=%0d lo=%0d up=%0d z=%0d",
                     $time, joint_out, bounded, accel_lower, accel_upper, zone);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) bound_q.push_back(damp_joint());
    end
  end

endmodule

// File: tb/joint_limit_velocity_damper_test.sv
`timescale 1ns / 100ps

module joint_limit_velocity_damper_test;
  import jlvd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_TIME_STEP;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [5:0] joint = '0;
  logic active = 1'b0;
  logic signed [31:0] position = '0, velocity = '0, pos_min = '0, pos_max = '0;
  logic signed [31:0] vel_min = '0, vel_max = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] joint_out;
  logic bounded;
  logic signed [31:0] accel_lower, accel_upper;
  logic [1:0] zone;
  int errors, pending, results_seen;
  int beats_sent = 0;
  bit quiet = 1'b0;

  always #1 clk = ~clk;

  joint_limit_velocity_damper dut (.*);
  joint_limit_velocity_damper_checker chk (.*);

  // receiver stalls about 8 in 100 unless in a quiet stretch
  always @(posedge clk) out_stall <= !quiet && ($urandom_range(99) < 8);

  // valid stays up between back-to-back beats, dropped only while idling
  task automatic put_joint(logic [5:0] j, logic a, logic signed [31:0] p, v, pmn, pmx,
                           vmn, vmx);
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    joint <= j;
    active <= a;
    position <= p;
    velocity <= v;
    pos_min <= pmn;
    pos_max <= pmx;
    vel_min <= vmn;
    vel_max <= vmx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly a well-formed joint with moderate numbers, near a limit, inside or just below its range; random otherwise
  task automatic random_joint();
    logic signed [31:0] pmn, pmx, p, v;
    int span;
    if ($urandom_range(9) < 2) begin
      put_joint(6'($urandom), 1'($urandom), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    end else begin
      span = $urandom_range(32'h0400_0000, 32'h0001_0000);
      pmn = $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
      pmx = pmn + span;
      case ($urandom_range(3))
        0: p = pmn + $urandom_range(span / 8);
        1: p = pmx - $urandom_range(span / 8);
        2: p = pmn + $urandom_range(span);
        default: p = pmn - $urandom_range(span / 4);
      endcase
      v = $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      put_joint(6'($urandom_range(7)), $urandom_range(9) != 0, p, v, pmn, pmx,
                -$signed($urandom_range(32'h0020_0000)),
                $signed($urandom_range(32'h0020_0000)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // extremes and special cases at reset settings
    put_joint(6'd0, 1'b1, 32'sh0, 32'sh0, -32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000);
    put_joint(6'd63, 1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 32'sh7fffffff);
    put_joint(6'd1, 1'b1, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000);
    put_joint(6'd2, 1'b1, -32'sh0fff0, 32'sh20000, -32'sh10000, 32'sh10000, -32'sh1, 32'sh1);
    put_joint(6'd2, 1'b1, -32'sh0ffe0, -32'sh20000, -32'sh10000, 32'sh10000, -32'sh1, 32'sh1);
    put_joint(6'd3, 1'b1, 32'sh0fff0, 32'sh30000, -32'sh10000, 32'sh10000, -32'sh1, 32'sh1);
    put_joint(6'd3, 1'b0, 32'sh0fff0, 32'sh30000, -32'sh10000, 32'sh10000, -32'sh1, 32'sh1);
    put_joint(6'd3, 1'b1, 32'sh0, 32'sh0, -32'sh10000, 32'sh10000, -32'sh1, 32'sh1);
    put_joint(6'd4, 1'b1, 32'sh5, 32'sh1, 32'sh5, 32'sh5, 32'sh0, 32'sh0);
    put_joint(6'd5, 1'b1, 32'sh0, 32'sh10000, 32'sh10000, -32'sh10000, -32'sh5, 32'sh5);
    put_joint(6'd6, 1'b0, 32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff,
              32'shffffffff, 32'shffffffff);
    drain();
    // zero period and extreme settings
    set_reg(CFG_TIME_STEP, 31'd0);
    set_reg(CFG_DAMPER_OFFSET, 31'h7fffffff);
    set_reg(CFG_INFLUENCE, 31'hffff);
    set_reg(CFG_SECURITY, 31'hffff);
    put_joint(6'd7, 1'b1, 32'sh100, 32'sh100, 32'sh0, 32'sh10000, 32'sh0, 32'sh100);
    put_joint(6'd8, 1'b1, 32'shff00, -32'sh100, 32'sh0, 32'sh10000, 32'sh0, 32'sh0);
    for (int i = 0; i < 60; i++) random_joint();
    drain();
    set_reg(CFG_TIME_STEP, 31'h7fffffff);
    set_reg(CFG_DAMPER_OFFSET, 31'd0);
    set_reg(CFG_INFLUENCE, 31'd0);
    set_reg(CFG_SECURITY, 31'd0);
    for (int i = 0; i < 60; i++) random_joint();
    drain();
    set_reg(CFG_TIME_STEP, 31'd1);
    set_reg(CFG_INFLUENCE, 31'd16384);
    set_reg(CFG_SECURITY, 31'd4096);
    set_reg(CFG_DAMPER_OFFSET, 31'h8000);
    quiet = 1'b1;
    for (int i = 0; i < 150; i++) random_joint();
    quiet = 1'b0;
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      set_reg(CFG_TIME_STEP, 31'($urandom_range(32'h20000, 1)));
      set_reg(CFG_DAMPER_OFFSET, 31'($urandom_range(32'h40000)));
      set_reg(CFG_INFLUENCE, 31'($urandom_range(65535, 3000)));
      set_reg(CFG_SECURITY, 31'($urandom_range(3000)));
      for (int i = 0; i < 215; i++) random_joint();
      drain();
    end
    $display("sent %0d joint beats over eight register settings, %0d bound results checked",
             beats_sent, results_seen);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #6000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
